// ===== hdl/ntc_thermistor_beta_converter_assert.svh =====
// ----------------------------------------------------------------------------
// NTC converter assertion macros
// Concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH
`define NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during rst
`define NTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntc converter: assertion failed");
// next-cycle implication
`define NTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntc converter: assertion failed");
`else
`define NTC_ASSERT_IMP(lbl, ante, cons)
`define NTC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// NTC converter package
// Widths, constants and types shared by the thermistor converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int SAMPLES_PER_READING = 5;
  localparam int ADC_FULL_SCALE      = 1023;
  localparam int FULL_SCALE_SUM      = SAMPLES_PER_READING * ADC_FULL_SCALE;

  localparam int ADC_W      = 10;
  localparam int SUM_W      = $clog2(FULL_SCALE_SUM + 1);
  localparam int CNT_W      = $clog2(SAMPLES_PER_READING + 1);
  localparam int RES_W      = 20;
  localparam int BETA_W     = 14;
  localparam int T0_W       = 9;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // shared multiplier operand width and log2 result layout
  localparam int MUL_W  = RES_W + SUM_W;
  localparam int EXP_W  = 6;
  localparam int LOG_W  = EXP_W + 32;
  localparam int LN_W   = 43;

  // shared restoring divider
  localparam int DVD_W  = 60;
  localparam int DVS_W  = 48;
  localparam int REM_W  = DVS_W + 1;
  localparam int DCNT_W = 6;
  localparam int Q_W    = 47;

  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam logic signed [TEMP_W-1:0] INVALID_TENTHS = -16'sd990;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT       = 16'sd32767;
  // 2731.5 in Q16
  localparam logic [41:0] KELVIN_OFFSET_Q16 = 42'd179011584;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES_RES  = 3'd0,
    REG_NOMINAL_RES = 3'd1,
    REG_BETA        = 3'd2,
    REG_NOMINAL_T   = 3'd3,
    REG_SENSOR_RDY  = 3'd4
  } cfg_reg_t;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_MUL_A    = 11'b000_0000_0010,
    ST_MUL_B    = 11'b000_0000_0100,
    ST_LOG_NORM = 11'b000_0000_1000,
    ST_LOG_SQ   = 11'b000_0001_0000,
    ST_LN_LO    = 11'b000_0010_0000,
    ST_LN_HI    = 11'b000_0100_0000,
    ST_DIV      = 11'b000_1000_0000,
    ST_COMB     = 11'b001_0000_0000,
    ST_RND      = 11'b010_0000_0000,
    ST_OUT      = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    DIV_Q    = 2'd0,
    DIV_INV0 = 2'd1,
    DIV_TEMP = 2'd2
  } div_sel_t;

endpackage

// ===== hdl/ntc_thermistor_beta_converter.sv =====
// ----------------------------------------------------------------------------
// NTC thermistor beta-equation converter
// Sums groups of ADC samples and converts each group to tenths of a degree C.
// ----------------------------------------------------------------------------
// A group that fails the sanity checks has its result registered as its closing
//   sample is taken; a good group is converted with 64 squarings on the shared
//   33x33 multiplier and three 60-step passes of the shared divider; a group that
//   saturates hot skips the last pass. Throughput: one sample per cycle while a
//   group fills, unless a result is unread at closing; none in conversion.
// Reset (rst, synchronous): sample sum and count cleared, config registers to defaults, no result.
module ntc_thermistor_beta_converter
  import ntc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [9:0] adc_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] temperature_tenths
  output logic [0:0]            m_axis_tuser,   // [0] reading_valid
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "ntc_thermistor_beta_converter_assert.svh"

  state_t state;

  logic [RES_W-1:0]       series_res;
  logic [RES_W-1:0]       nominal_res;
  logic [BETA_W-1:0]      beta;
  logic signed [T0_W-1:0] nominal_t;
  logic                   sensor_ready;

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] samples_taken;
  logic [SUM_W-1:0] grp_sum;

  logic [MUL_W-1:0]  a_val, b_val;
  logic              log_sel;
  logic [EXP_W-1:0]  log_exp;
  logic [31:0]       mant, frac;
  logic [4:0]        iter;
  logic [LOG_W-1:0]  la, diff;
  logic              neg;
  logic [LN_W-1:0]   ln_acc;

  logic [REM_W-1:0]  div_rem;
  logic [DVD_W-1:0]  div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [DCNT_W-1:0] div_cnt;
  div_sel_t          div_sel;
  logic [Q_W-1:0]    q_val, inv0;
  logic [DVD_W-1:0]  v_val;
  logic [25:0]       mag;
  logic              rnd_neg;

  logic                     out_valid;
  logic [TEMP_W-1:0]        out_temp;
  logic                     out_flag;

  // ---------------- handshake ----------------
  logic closing, in_acc, out_acc;
  assign closing       = (samples_taken == CNT_W'(SAMPLES_PER_READING - 1));
  assign s_axis_tready = (state == ST_IDLE) && !(out_valid && closing);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_temp;
  assign m_axis_tuser  = out_flag;

  logic [SUM_W-1:0] new_sum;
  logic             bad_group;
  assign new_sum   = sample_sum + SUM_W'(s_axis_tdata[ADC_W-1:0]);
  assign bad_group = !sensor_ready || (series_res == '0) || (nominal_res == '0) ||
                     (beta == '0) || (new_sum == '0) ||
                     (new_sum >= SUM_W'(FULL_SCALE_SUM));

  // ---------------- shared multiplier ----------------
  logic [MUL_W-1:0]   mul_x, mul_y;
  logic [2*MUL_W-1:0] mul_p;
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      ST_MUL_A: begin
        mul_x = MUL_W'(series_res);
        mul_y = MUL_W'(grp_sum);
      end
      ST_MUL_B: begin
        mul_x = MUL_W'(nominal_res);
        mul_y = MUL_W'(SUM_W'(FULL_SCALE_SUM) - grp_sum);
      end
      ST_LOG_SQ: begin
        mul_x = MUL_W'(mant);
        mul_y = MUL_W'(mant);
      end
      ST_LN_LO: begin
        mul_x = MUL_W'(diff[18:0]);
        mul_y = MUL_W'(LN2_Q24);
      end
      ST_LN_HI: begin
        mul_x = MUL_W'(diff[LOG_W-1:19]);
        mul_y = MUL_W'(LN2_Q24);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign mul_p = {{MUL_W{1'b0}}, mul_x} * {{MUL_W{1'b0}}, mul_y};

  // ---------------- log2 normalize and square step ----------------
  logic [MUL_W-1:0] log_x, norm;
  logic [EXP_W-1:0] log_k;
  always_comb begin
    log_x = log_sel ? b_val : a_val;
    log_k = '0;
    for (int i = 0; i < MUL_W; i++) begin
      if (log_x[i]) log_k = EXP_W'(i);
    end
    if (log_k >= EXP_W'(31)) norm = log_x >> (log_k - EXP_W'(31));
    else norm = log_x << (EXP_W'(31) - log_k);
  end

  logic [32:0]      sq;
  logic [31:0]      frac_nx, mant_nx;
  logic [LOG_W-1:0] log_res;
  assign sq      = mul_p[63:31];
  assign mant_nx = sq[32] ? sq[32:1] : sq[31:0];
  assign frac_nx = {frac[30:0], sq[32]};
  assign log_res = {log_exp, frac_nx};

  logic [61:0] ln_sum;
  assign ln_sum = {19'b0, ln_acc} + {mul_p[LN_W-1:0], 19'b0};

  // ---------------- shared divider step ----------------
  logic [REM_W-1:0] rem_sh, dvs_ext, rem_nx;
  logic             q_bit;
  logic [DVD_W-1:0] quo_nx;
  assign dvs_ext = {1'b0, div_dvs};
  assign rem_sh  = {div_rem[REM_W-2:0], div_quo[DVD_W-1]};
  assign q_bit   = (rem_sh >= dvs_ext);
  assign rem_nx  = q_bit ? (rem_sh - dvs_ext) : rem_sh;
  assign quo_nx  = {div_quo[DVD_W-2:0], q_bit};

  logic signed [16:0] t0_ext, t0h_s;
  logic [15:0]        t0h;
  assign t0_ext = 17'(nominal_t);
  assign t0h_s  = t0_ext * 17'sd100 + 17'sd27315;
  assign t0h    = t0h_s[15:0];

  logic [DVS_W-1:0] u_val;
  assign u_val = neg ? (DVS_W'(inv0) - DVS_W'(q_val)) : (DVS_W'(inv0) + DVS_W'(q_val));

  // ---------------- rounding ----------------
  logic [40:0]        v_cap;
  logic signed [41:0] w_val;
  logic [41:0]        w_abs;
  assign v_cap = (v_val > DVD_W'(64'd1 << 40)) ? 41'(64'd1 << 40) : v_val[40:0];
  assign w_val = signed'({1'b0, v_cap}) - signed'(KELVIN_OFFSET_Q16);
  assign w_abs = (w_val[41] ? 42'(-w_val) : 42'(w_val)) + 42'd32768;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      series_res    <= RES_W'(10000);
      nominal_res   <= RES_W'(10000);
      beta          <= BETA_W'(3950);
      nominal_t     <= 9'sd25;
      sensor_ready  <= 1'b0;
      sample_sum    <= '0;
      samples_taken <= '0;
      out_valid     <= 1'b0;
      log_sel       <= 1'b0;
      iter          <= '0;
      div_cnt       <= '0;
      div_sel       <= DIV_Q;
    end else begin
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_index))
          REG_SERIES_RES:  series_res   <= cfg_wdata[RES_W-1:0];
          REG_NOMINAL_RES: nominal_res  <= cfg_wdata[RES_W-1:0];
          REG_BETA:        beta         <= cfg_wdata[BETA_W-1:0];
          REG_NOMINAL_T:   nominal_t    <= signed'(cfg_wdata[T0_W-1:0]);
          REG_SENSOR_RDY:  sensor_ready <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_acc) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (closing) begin
              sample_sum    <= '0;
              samples_taken <= '0;
              grp_sum       <= new_sum;
              if (bad_group) begin
                out_valid <= 1'b1;
                out_temp  <= INVALID_TENTHS;
                out_flag  <= 1'b0;
              end else begin
                state <= ST_MUL_A;
              end
            end else begin
              sample_sum    <= new_sum;
              samples_taken <= samples_taken + 1'b1;
            end
          end
        end
        ST_MUL_A: begin
          a_val <= mul_p[MUL_W-1:0];
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          b_val   <= mul_p[MUL_W-1:0];
          log_sel <= 1'b0;
          state   <= ST_LOG_NORM;
        end
        ST_LOG_NORM: begin
          log_exp <= log_k;
          mant    <= norm[31:0];
          frac    <= '0;
          iter    <= '0;
          state   <= ST_LOG_SQ;
        end
        ST_LOG_SQ: begin
          mant <= mant_nx;
          frac <= frac_nx;
          iter <= iter + 1'b1;
          if (iter == 5'd31) begin
            if (!log_sel) begin
              la      <= log_res;
              log_sel <= 1'b1;
              state   <= ST_LOG_NORM;
            end else begin
              neg   <= (la < log_res);
              diff  <= (la < log_res) ? (log_res - la) : (la - log_res);
              state <= ST_LN_LO;
            end
          end
        end
        ST_LN_LO: begin
          ln_acc <= mul_p[LN_W-1:0];
          state  <= ST_LN_HI;
        end
        ST_LN_HI: begin
          // ln magnitude scaled by 2^8 over beta
          div_quo <= DVD_W'({ln_sum[61:24], 8'b0});
          div_dvs <= DVS_W'(beta);
          div_rem <= '0;
          div_cnt <= '0;
          div_sel <= DIV_Q;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= rem_nx;
          div_quo <= quo_nx;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(DVD_W - 1)) begin
            div_rem <= '0;
            div_cnt <= '0;
            case (div_sel)
              DIV_Q: begin
                q_val   <= quo_nx[Q_W-1:0];
                div_quo <= (DVD_W'(100) << 40) + DVD_W'(t0h[15:1]);
                div_dvs <= DVS_W'(t0h);
                div_sel <= DIV_INV0;
              end
              DIV_INV0: begin
                inv0  <= quo_nx[Q_W-1:0];
                state <= ST_COMB;
              end
              default: begin
                v_val <= quo_nx;
                state <= ST_RND;
              end
            endcase
          end
        end
        ST_COMB: begin
          if (neg && (q_val >= inv0)) begin
            out_valid <= 1'b1;
            out_temp  <= TEMP_HOT;
            out_flag  <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            div_quo <= DVD_W'(10) << 56;
            div_dvs <= u_val;
            div_rem <= '0;
            div_cnt <= '0;
            div_sel <= DIV_TEMP;
            state   <= ST_DIV;
          end
        end
        ST_RND: begin
          mag     <= w_abs[41:16];
          rnd_neg <= w_val[41];
          state   <= ST_OUT;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_flag  <= 1'b1;
          if (rnd_neg) begin
            out_temp <= (mag > 26'd32768) ? 16'h8000 : TEMP_W'(-mag);
          end else begin
            out_temp <= (mag > 26'd32767) ? TEMP_HOT : mag[TEMP_W-1:0];
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `NTC_ASSERT_NXT(a_group_closes, in_acc && closing, state != ST_IDLE || out_valid)
  `NTC_ASSERT_IMP(a_invalid_code, out_valid && !out_flag, out_temp == INVALID_TENTHS)
  `NTC_ASSERT_IMP(a_mant_normal, state == ST_LOG_SQ, mant[31])
  `NTC_ASSERT_IMP(a_rem_bound, state == ST_DIV, div_rem < dvs_ext)

endmodule
